### rtl/descriptor_slot_allocator_top_macros.svh
// Assertion macros for the descriptor slot allocator.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Check on every clock edge outside reset.
`define DSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define DSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dsa_pkg.sv
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

  localparam int SLOT_W         = 10;
  localparam int COUNT_W        = 4;
  localparam int RESULT_LIMIT   = 8;
  localparam int SLOT_COUNT_DEF = 1024;
  localparam int MAX_BATCH_DEF  = 8;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [COUNT_W-1:0]  count;
    logic [SLOT_W-1:0]   slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_res;
    status_t             status;
    logic                last;
  } out_item_t;

endpackage

### rtl/descriptor_slot_allocator_top.sv
// Top level of the descriptor slot allocator: free stack in RAM plus fresh-index counter.
//
//   channel  ports                        beat accepted when
//   input    start, busy, in_data         start high and busy low at the clock edge
//   result   out_strobe, out_data         out_strobe high, each beat shown for exactly one cycle
//
// A release keeps busy low. A successful allocate of n slots keeps busy high in S_ALLOC,
// taking one stack read or fresh index per cycle; each result appears in the cycle after
// its read, through the RAM read register. A failing allocate that takes t slots reads the
// d stacked ones, appends the remaining fresh indices, writes all t back one per cycle and
// keeps busy high through S_GATHER and S_PUSH; heap_full follows in the first idle cycle.
// Synchronous reset empties the stack and the fresh counter at once; the stack RAM needs
// no clearing pass. The receiver cannot stall.
`include "descriptor_slot_allocator_top_macros.svh"

module descriptor_slot_allocator_top #(
  parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF,
  parameter int MAX_BATCH  = dsa_pkg::MAX_BATCH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dsa_pkg::in_item_t   in_data,
  output logic                busy,
  output logic                out_strobe,
  output dsa_pkg::out_item_t  out_data
);

  import dsa_pkg::*;

  localparam int AW        = $clog2(SLOT_COUNT);
  localparam int DW        = $clog2(SLOT_COUNT + 1);
  localparam int CW        = (DW + 1 > COUNT_W) ? DW + 1 : COUNT_W;
  localparam int BW        = $clog2(RESULT_LIMIT);
  localparam int BATCH_CAP = (MAX_BATCH < RESULT_LIMIT) ? MAX_BATCH : RESULT_LIMIT;

  localparam logic [DW-1:0]      SLOT_COUNT_D = DW'(SLOT_COUNT);
  localparam logic [COUNT_W-1:0] BATCH_CAP_C  = COUNT_W'(BATCH_CAP);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_GATHER,
    S_PUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [DW-1:0]       fresh_r, fresh_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [BW-1:0]       n_r, n_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [SLOT_W-1:0]   buf_r [RESULT_LIMIT];
  logic [SLOT_W-1:0]   buf_nxt [RESULT_LIMIT];
  logic                pipe_v_r, pipe_v_nxt;
  logic                pipe_pop_r, pipe_pop_nxt;
  logic [SLOT_W-1:0]   pipe_val_r, pipe_val_nxt;
  status_t             pipe_st_r, pipe_st_nxt;
  logic                pipe_last_r, pipe_last_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SLOT_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SLOT_W-1:0]   ram_rdata;

  logic [COUNT_W-1:0]  want;
  logic [CW-1:0]       avail;
  logic [DW-1:0]       depth_m1;

  dsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != S_IDLE);
  assign want     = (in_data.count > BATCH_CAP_C) ? BATCH_CAP_C : in_data.count;
  assign avail    = CW'(depth_r) + CW'(SLOT_COUNT) - CW'(fresh_r);
  assign depth_m1 = depth_r - DW'(1);

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    rd_pend_nxt   = 1'b0;
    buf_nxt       = buf_r;
    pipe_v_nxt    = 1'b0;
    pipe_pop_nxt  = 1'b0;
    pipe_val_nxt  = pipe_val_r;
    pipe_st_nxt   = pipe_st_r;
    pipe_last_nxt = pipe_last_r;
    ram_we        = 1'b0;
    ram_waddr     = depth_r[AW-1:0];
    ram_wdata     = in_data.slot;
    ram_re        = 1'b0;
    ram_raddr     = depth_m1[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.kind == KIND_RELEASE) begin
            if (depth_r < SLOT_COUNT_D) begin
              ram_we    = 1'b1;
              depth_nxt = depth_r + DW'(1);
            end
          end else if (want != '0) begin
            if (avail >= CW'(want)) begin
              rem_nxt   = want;
              state_nxt = S_ALLOC;
            end else begin
              n_nxt     = '0;
              state_nxt = S_GATHER;
            end
          end
        end
      end
      S_ALLOC: begin
        if (depth_r != '0) begin
          ram_re       = 1'b1;
          depth_nxt    = depth_m1;
          pipe_pop_nxt = 1'b1;
        end else begin
          pipe_val_nxt = SLOT_W'(fresh_r);
          fresh_nxt    = fresh_r + DW'(1);
        end
        pipe_v_nxt    = 1'b1;
        pipe_st_nxt   = STATUS_OK;
        pipe_last_nxt = (rem_r == COUNT_W'(1));
        rem_nxt       = rem_r - COUNT_W'(1);
        if (rem_r == COUNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_GATHER: begin
        if (rd_pend_r) begin
          buf_nxt[n_r] = ram_rdata;
          n_nxt        = n_r + BW'(1);
        end
        if (depth_r != '0) begin
          ram_re      = 1'b1;
          depth_nxt   = depth_m1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          if (fresh_r < SLOT_COUNT_D) begin
            buf_nxt[n_r] = SLOT_W'(fresh_r);
            n_nxt        = n_r + BW'(1);
            fresh_nxt    = fresh_r + DW'(1);
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (n_r == '0) begin
          pipe_v_nxt    = 1'b1;
          pipe_val_nxt  = '0;
          pipe_st_nxt   = STATUS_FULL;
          pipe_last_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (depth_r < SLOT_COUNT_D) begin
            ram_we    = 1'b1;
            ram_wdata = buf_r[0];
            depth_nxt = depth_r + DW'(1);
          end
          for (int i = 0; i < RESULT_LIMIT - 1; i++) begin
            buf_nxt[i] = buf_r[i+1];
          end
          n_nxt = n_r - BW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    pipe_val_r  <= pipe_val_nxt;
    pipe_st_r   <= pipe_st_nxt;
    pipe_last_r <= pipe_last_nxt;
    rem_r       <= rem_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      depth_r    <= '0;
      fresh_r    <= '0;
      n_r        <= '0;
      rd_pend_r  <= 1'b0;
      pipe_v_r   <= 1'b0;
      pipe_pop_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      fresh_r    <= fresh_nxt;
      n_r        <= n_nxt;
      rd_pend_r  <= rd_pend_nxt;
      pipe_v_r   <= pipe_v_nxt;
      pipe_pop_r <= pipe_pop_nxt;
    end
  end

  assign out_strobe        = pipe_v_r;
  assign out_data.slot_res = pipe_pop_r ? ram_rdata : pipe_val_r;
  assign out_data.status   = pipe_st_r;
  assign out_data.last     = pipe_last_r;

  `DSA_ASSERT(a_depth_bound, depth_r <= SLOT_COUNT_D, "stack depth beyond pool size")
  `DSA_ASSERT(a_fresh_bound, fresh_r <= SLOT_COUNT_D, "fresh index beyond pool size")
  `DSA_ASSERT(a_alloc_last,
              (state_r == S_ALLOC && rem_r == COUNT_W'(1)) |=>
                (out_strobe && out_data.last && state_r == S_IDLE),
              "final allocate beat not marked last")
  `DSA_ASSERT(a_full_beat,
              (out_strobe && out_data.status == STATUS_FULL) |->
                (out_data.slot_res == '0 && out_data.last),
              "heap_full beat malformed")
  `DSA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe, "result beat right after reset")

endmodule

### rtl/dsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
